[src/assert_macros.svh]
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/itsb_pkg.sv]
// Package: types and constants of the interval timer statistics bank.
package itsb_pkg;
  localparam int NumTimers = 16;
  localparam int IdW = 4;
  localparam int TimeW = 32;
  localparam int TotW = 48;
  localparam int CntW = 32;
  localparam int CfgW = 5;
  localparam int DivSteps = TotW;
  localparam int DivCntW = 6;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OpRead = 2'd0, OpStart = 2'd1, OpStop = 2'd2, OpClear = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StDone = 2'd0, StInvalid = 2'd1, StIdleStop = 2'd2, StRsvd = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BkIdle, BkDiv, BkOut
  } bk_state_e;

  // Classified item passed from front to back.
  typedef struct packed {
    logic            valid_id;
    op_e             op;
    logic [IdW-1:0]  id;
    logic [TimeW-1:0] ts;
  } cmd_t;

  // Result item.
  typedef struct packed {
    status_e          status;
    logic             running;
    logic [TimeW-1:0] last_elapsed;
    logic [TimeW-1:0] average;
    logic [TimeW-1:0] minimum;
    logic [TimeW-1:0] maximum;
    logic [TotW-1:0]  total;
    logic [CntW-1:0]  sample_count;
  } res_t;
endpackage

[src/itsb_front.sv]
// Front: classify items against the timers-in-use register and queue them.
module itsb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [itsb_pkg::IdW-1:0]    id_i,
  input  logic [itsb_pkg::TimeW-1:0]  ts_i,
  input  logic [itsb_pkg::CfgW-1:0]   limit_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_take_i,
  output itsb_pkg::cmd_t              cmd_o
);
  itsb_pkg::cmd_t q_mem [itsb_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  itsb_pkg::cmd_t c;

  assign full = (cnt_q == 2'(itsb_pkg::QDepth));
  assign wr = push && !full;
  assign rd = cmd_take_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_mem[rp_q];

  always_comb begin
    c.op = itsb_pkg::op_e'(op_i);
    c.id = id_i;
    c.ts = ts_i;
    // Values above the bank size act as the bank size; the 4-bit id is always below it.
    c.valid_id = ({1'b0, id_i} < limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule

[src/itsb_back.sv]
// Back: update timer state, divide for the average, hold the result.
module itsb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_take_o,
  input  itsb_pkg::cmd_t cmd_i,
  output logic           empty,
  input  logic           pop,
  output itsb_pkg::res_t res_o
);
  localparam int N = itsb_pkg::NumTimers;
  localparam int TW = itsb_pkg::TimeW;
  localparam int SW = itsb_pkg::TotW;
  localparam int CW = itsb_pkg::CntW;

  logic [N-1:0] run_q;
  logic [TW-1:0] start_q [N];
  logic [TW-1:0] el_q [N];
  logic [SW-1:0] tot_q [N];
  logic [CW-1:0] cnt_q [N];
  logic [TW-1:0] min_q [N];
  logic [TW-1:0] max_q [N];

  itsb_pkg::bk_state_e st_q, st_d;
  itsb_pkg::res_t res_q;
  logic [SW-1:0] rem_q, quo_q;
  logic [CW-1:0] dvs_q;
  logic [itsb_pkg::DivCntW-1:0] dcnt_q;

  logic [itsb_pkg::IdW-1:0] t;
  logic [TW-1:0] e;
  logic [SW:0] tsum;
  logic [CW:0] trial;
  logic [SW-1:0] rsh;
  logic take, div_last;
  itsb_pkg::res_t nr;
  logic n_run;
  logic [TW-1:0] n_el, n_min, n_max;
  logic [SW-1:0] n_tot;
  logic [CW-1:0] n_cnt;
  itsb_pkg::status_e n_st;

  assign t = cmd_i.id;
  assign take = (st_q == itsb_pkg::BkIdle) && cmd_valid_i;
  assign cmd_take_o = take;
  assign empty = (st_q != itsb_pkg::BkOut);
  assign res_o = res_q;
  assign div_last = (dcnt_q == itsb_pkg::DivCntW'(itsb_pkg::DivSteps - 1));

  // Next value of the addressed timer.
  always_comb begin
    e = cmd_i.ts - start_q[t];
    tsum = {1'b0, tot_q[t]} + {{(SW-TW+1){1'b0}}, e};
    n_run = run_q[t];
    n_el = el_q[t];
    n_tot = tot_q[t];
    n_cnt = cnt_q[t];
    n_min = min_q[t];
    n_max = max_q[t];
    n_st = itsb_pkg::StDone;
    unique case (cmd_i.op)
      itsb_pkg::OpStart: n_run = 1'b1;
      itsb_pkg::OpStop: begin
        if (!run_q[t]) begin
          n_st = itsb_pkg::StIdleStop;
        end else begin
          n_run = 1'b0;
          n_el = e;
          if (~&cnt_q[t]) n_cnt = cnt_q[t] + 1'b1;
          n_tot = tsum[SW] ? {SW{1'b1}} : tsum[SW-1:0];
          if (e < min_q[t]) n_min = e;
          if (e > max_q[t]) n_max = e;
        end
      end
      itsb_pkg::OpClear: begin
        n_run = 1'b0;
        n_el = '0;
        n_tot = '0;
        n_cnt = '0;
        n_min = '1;
        n_max = '0;
      end
      default: ;
    endcase
    nr.status = n_st;
    nr.running = n_run;
    nr.last_elapsed = n_el;
    nr.average = '0;
    nr.minimum = (n_cnt != '0) ? n_min : '0;
    nr.maximum = n_max;
    nr.total = n_tot;
    nr.sample_count = n_cnt;
    if (!cmd_i.valid_id) begin
      nr = '0;
      nr.status = itsb_pkg::StInvalid;
    end
  end

  // Restoring divide step.
  always_comb begin
    rsh = {rem_q[SW-2:0], quo_q[SW-1]};
    trial = {1'b0, rsh[CW-1:0]} - {1'b0, dvs_q};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      itsb_pkg::BkIdle: if (take) begin
        st_d = (cmd_i.valid_id && n_cnt != '0) ? itsb_pkg::BkDiv : itsb_pkg::BkOut;
      end
      itsb_pkg::BkDiv: if (div_last) st_d = itsb_pkg::BkOut;
      itsb_pkg::BkOut: if (pop) st_d = itsb_pkg::BkIdle;
      default: st_d = itsb_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= itsb_pkg::BkIdle;
      run_q <= '0;
      for (int i = 0; i < N; i++) begin
        start_q[i] <= '0;
        el_q[i] <= '0;
        tot_q[i] <= '0;
        cnt_q[i] <= '0;
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (take && cmd_i.valid_id) begin
        run_q[t] <= n_run;
        el_q[t] <= n_el;
        tot_q[t] <= n_tot;
        cnt_q[t] <= n_cnt;
        min_q[t] <= n_min;
        max_q[t] <= n_max;
        if (cmd_i.op == itsb_pkg::OpStart) start_q[t] <= cmd_i.ts;
        else if (cmd_i.op == itsb_pkg::OpClear) start_q[t] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (take) begin
      dcnt_q <= '0;
    end else if (st_q == itsb_pkg::BkDiv) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // Payload: remainder stays below the divisor so fits in CW bits.
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= nr;
      rem_q <= '0;
      quo_q <= n_tot;
      dvs_q <= n_cnt;
    end else if (st_q == itsb_pkg::BkDiv) begin
      if (!trial[CW] || rsh[CW]) begin
        rem_q <= {{(SW-CW){1'b0}}, rsh[CW-1:0] - dvs_q};
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
      if (div_last) begin
        if (!trial[CW] || rsh[CW]) begin
          res_q.average <= (|quo_q[SW-2:TW-1]) ? '1 : {quo_q[TW-2:0], 1'b1};
        end else begin
          res_q.average <= (|quo_q[SW-2:TW-1]) ? '1 : {quo_q[TW-2:0], 1'b0};
        end
      end
    end
  end
endmodule

[src/interval_timer_stats_bank_top.sv]
// Top level of the interval timer statistics bank.
// Usage:
//   Input queue: drive op/id/timestamp and raise push; the item is taken at
//   an edge where push is high and full is low. A two-entry queue sits in
//   front, so up to two items can wait while the back end works.
//   Result queue: while empty is low the result ports hold the oldest
//   result; raise pop to take it.
//   Config: write timers_in_use through cfg_valid/cfg_ready (always ready),
//   only while the block is idle. Values above 16 act as 16.
// Flow: the back end handles one item at a time. An item whose timer has
//   a nonzero sample count runs a 48-step radix-2 divider for the average
//   once it has passed the front queue into the back end, and its result
//   shows when the divider is done; others show as soon as they are taken.
//   The back end takes no new item until the held result has been popped.
// Reset: all timers are cleared (minimum store to all ones), counters and
//   queues emptied, timers_in_use becomes 0, so every id is invalid.
// Stall: while a result is not popped the back end holds it and stops;
//   the front queue keeps taking items until it is full.
module interval_timer_stats_bank_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  operation_i,
  input  logic [3:0]                  timer_id_i,
  input  logic [31:0]                 timestamp_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  status_o,
  output logic                        running_o,
  output logic [31:0]                 last_elapsed_o,
  output logic [31:0]                 average_o,
  output logic [31:0]                 minimum_o,
  output logic [31:0]                 maximum_o,
  output logic [47:0]                 total_o,
  output logic [31:0]                 sample_count_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [4:0]                  cfg_data
);
  logic [itsb_pkg::CfgW-1:0] limit_q;
  logic cmd_valid, cmd_take;
  itsb_pkg::cmd_t cmd;
  itsb_pkg::res_t res;

  assign cfg_ready = 1'b1;

  // Hold the timers-in-use register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= '0;
    else if (cfg_valid) limit_q <= cfg_data;
  end

  itsb_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .op_i(operation_i), .id_i(timer_id_i), .ts_i(timestamp_i),
    .limit_i(limit_q),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  itsb_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .empty, .pop, .res_o(res)
  );

  assign status_o = res.status;
  assign running_o = res.running;
  assign last_elapsed_o = res.last_elapsed;
  assign average_o = res.average;
  assign minimum_o = res.minimum;
  assign maximum_o = res.maximum;
  assign total_o = res.total;
  assign sample_count_o = res.sample_count;
endmodule

[src/itsb_checker.sv]
// Port checker for the interval timer statistics bank, with its bind.
`include "assert_macros.svh"
module itsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic        running_o,
  input logic [31:0] minimum_o,
  input logic [31:0] maximum_o,
  input logic [31:0] sample_count_o,
  input logic [47:0] total_o
);
  `ASSERT_IMPL(a_status, clk_i, rst_ni, !empty, status_o != itsb_pkg::StRsvd, "bad status")
  `ASSERT_IMPL(a_minmax, clk_i, rst_ni, !empty && sample_count_o != 0,
    minimum_o <= maximum_o, "min above max")
  `ASSERT_IMPL(a_nocnt, clk_i, rst_ni, !empty && sample_count_o == 0,
    total_o == 0 && minimum_o == 0, "stats without samples")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(total_o),
    "result dropped")
  `ASSERT_IMPL(a_inv, clk_i, rst_ni, !empty && status_o == itsb_pkg::StInvalid,
    !running_o && sample_count_o == 0, "invalid result not zero")
endmodule

bind interval_timer_stats_bank_top itsb_checker u_itsb_checker (.*);

[sim/testbench.sv]
// Testbench for the interval timer statistics bank, checked against a local model.
module testbench;
  localparam int LimitCycles = 1000000;
  localparam int SettleCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = '0;
  logic [3:0]  timer_id_i = '0;
  logic [31:0] timestamp_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o;
  logic        running_o;
  logic [31:0] last_elapsed_o, average_o, minimum_o, maximum_o, sample_count_o;
  logic [47:0] total_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  interval_timer_stats_bank_top i_dut (.*);

  // Clock: period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the timer bank
  logic [itsb_pkg::CfgW-1:0]  timers_cfg;
  logic                       run_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TimeW-1:0] start_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TimeW-1:0] elapsed_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TotW-1:0]  total_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::CntW-1:0]  count_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TimeW-1:0] min_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TimeW-1:0] max_q [itsb_pkg::NumTimers];
  logic [itsb_pkg::TimeW-1:0] now_q [itsb_pkg::NumTimers];  // stimulus clock per timer

  itsb_pkg::res_t stats_pending[$];
  int   n_fail = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   cycle_cnt = 0;
  bit   steady = 1'b0;  // suppress idling on both sides

  function automatic void wipe_timer(int t);
    run_q[t] = 1'b0;
    start_q[t] = '0;
    elapsed_q[t] = '0;
    total_q[t] = '0;
    count_q[t] = '0;
    min_q[t] = '1;
    max_q[t] = '0;
  endfunction

  // Apply one item to the local bank and return the statistics it yields.
  function automatic itsb_pkg::res_t apply_timer_op(itsb_pkg::op_e op, logic [3:0] id,
                                                    logic [31:0] ts);
    itsb_pkg::res_t r;
    int lim;
    int t;
    logic [itsb_pkg::TimeW-1:0] e;
    logic [itsb_pkg::TotW-1:0] q;
    r = '0;
    lim = (timers_cfg > itsb_pkg::NumTimers) ? itsb_pkg::NumTimers : int'(timers_cfg);
    t = int'(id);
    if (t >= lim) begin
      r.status = itsb_pkg::StInvalid;
      return r;
    end
    r.status = itsb_pkg::StDone;
    case (op)
      itsb_pkg::OpStart: begin
        start_q[t] = ts;
        run_q[t] = 1'b1;
      end
      itsb_pkg::OpStop: begin
        if (!run_q[t]) begin
          r.status = itsb_pkg::StIdleStop;
        end else begin
          e = ts - start_q[t];
          elapsed_q[t] = e;
          run_q[t] = 1'b0;
          if (count_q[t] != '1) count_q[t]++;
          if ({itsb_pkg::TotW{1'b1}} - total_q[t] < itsb_pkg::TotW'(e)) total_q[t] = '1;
          else total_q[t] += itsb_pkg::TotW'(e);
          if (e < min_q[t]) min_q[t] = e;
          if (e > max_q[t]) max_q[t] = e;
        end
      end
      itsb_pkg::OpClear: wipe_timer(t);
      default: ;
    endcase
    r.running = run_q[t];
    r.last_elapsed = elapsed_q[t];
    if (count_q[t] != 0) begin
      q = total_q[t] / itsb_pkg::TotW'(count_q[t]);
      r.average = (q > itsb_pkg::TotW'(32'hFFFF_FFFF)) ? '1 : q[itsb_pkg::TimeW-1:0];
      r.minimum = min_q[t];
    end
    r.maximum = max_q[t];
    r.total = total_q[t];
    r.sample_count = count_q[t];
    return r;
  endfunction

  // Send one item; hold push high across back-to-back items.
  task automatic send_item(itsb_pkg::op_e op, logic [3:0] id, logic [31:0] ts);
    if (!steady && $urandom_range(99) < 8) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    operation_i = op;
    timer_id_i = id;
    timestamp_i = ts;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    stats_pending.push_back(apply_timer_op(op, id, ts));
    n_items++;
    @(negedge clk_i);
  endtask

  // Lower push and wait until every result has come back.
  task automatic drain;
    push = 1'b0;
    while (stats_pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_timers_in_use(logic [4:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    timers_cfg = v;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Advance one timer's stimulus clock and return the new timestamp.
  function automatic logic [31:0] tick(int t);
    case ($urandom_range(9))
      0: now_q[t] = $urandom;
      1: now_q[t] += 32'hFFFF_FFFF - $urandom_range(3);
      2: now_q[t] += $urandom;
      default: now_q[t] += $urandom_range(0, 5000);
    endcase
    return now_q[t];
  endfunction

  // Result side: pop idles at random, outputs sampled at the rising edge.
  always @(negedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    itsb_pkg::res_t exp_r;
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (stats_pending.size() == 0) begin
        $error("result with no item outstanding");
        n_fail++;
      end else begin
        exp_r = stats_pending.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          n_fail++;
        end
        if (running_o !== exp_r.running) begin
          $error("running: expected %0d, got %0d", exp_r.running, running_o);
          n_fail++;
        end
        if (last_elapsed_o !== exp_r.last_elapsed) begin
          $error("last_elapsed: expected %0d, got %0d", exp_r.last_elapsed, last_elapsed_o);
          n_fail++;
        end
        if (average_o !== exp_r.average) begin
          $error("average: expected %0d, got %0d", exp_r.average, average_o);
          n_fail++;
        end
        if (minimum_o !== exp_r.minimum) begin
          $error("minimum: expected %0d, got %0d", exp_r.minimum, minimum_o);
          n_fail++;
        end
        if (maximum_o !== exp_r.maximum) begin
          $error("maximum: expected %0d, got %0d", exp_r.maximum, maximum_o);
          n_fail++;
        end
        if (total_o !== exp_r.total) begin
          $error("total: expected %0d, got %0d", exp_r.total, total_o);
          n_fail++;
        end
        if (sample_count_o !== exp_r.sample_count) begin
          $error("sample_count: expected %0d, got %0d", exp_r.sample_count, sample_count_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: end the run once the cycle limit is passed.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // After reset every id is invalid.
  task automatic test_reset_invalid;
    send_item(itsb_pkg::OpRead, 4'd0, 32'd0);
    send_item(itsb_pkg::OpStart, 4'd15, 32'hFFFF_FFFF);
  endtask

  // Every operation, idle stop, restart, wraparound, clear and the id extremes.
  task automatic test_directed_ops;
    write_timers_in_use(5'd16);
    send_item(itsb_pkg::OpStop, 4'd0, 32'd5);            // idle stop
    send_item(itsb_pkg::OpStart, 4'd0, 32'd100);
    send_item(itsb_pkg::OpStart, 4'd0, 32'd200);         // restart overwrites start time
    send_item(itsb_pkg::OpStop, 4'd0, 32'd250);
    send_item(itsb_pkg::OpRead, 4'd0, 32'd0);
    send_item(itsb_pkg::OpStart, 4'd15, 32'hFFFF_FFF0);
    send_item(itsb_pkg::OpStop, 4'd15, 32'h0000_0010);   // wraps around
    send_item(itsb_pkg::OpStart, 4'd15, 32'd0);
    send_item(itsb_pkg::OpStop, 4'd15, 32'hFFFF_FFFF);   // largest interval
    send_item(itsb_pkg::OpStart, 4'd15, 32'd7);
    send_item(itsb_pkg::OpStop, 4'd15, 32'd7);           // zero interval
    send_item(itsb_pkg::OpStop, 4'd15, 32'd9);
    send_item(itsb_pkg::OpStart, 4'd15, 32'd1);
    send_item(itsb_pkg::OpClear, 4'd15, 32'd3);          // clear drops run flag too
    send_item(itsb_pkg::OpRead, 4'd15, 32'hAAAA_5555);
  endtask

  // Register limits: above 16 acts as 16, small values reject high ids.
  task automatic test_config_limits;
    write_timers_in_use(5'd31);
    send_item(itsb_pkg::OpRead, 4'd15, 32'd0);
    write_timers_in_use(5'd1);
    send_item(itsb_pkg::OpRead, 4'd0, 32'd0);
    send_item(itsb_pkg::OpStart, 4'd1, 32'd0);
    write_timers_in_use(5'd0);
    send_item(itsb_pkg::OpRead, 4'd0, 32'd0);
  endtask

  // Random phases: mostly start/stop pairs with random timing, some noise.
  task automatic test_random_traffic;
    int t;
    int lim;
    itsb_pkg::op_e op;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_timers_in_use(5'd16);
        4: write_timers_in_use(5'd31);
        7: write_timers_in_use(5'd0);
        default: write_timers_in_use(5'($urandom_range(1, 31)));
      endcase
      steady = (ph == 3);
      lim = (timers_cfg > itsb_pkg::NumTimers) ? itsb_pkg::NumTimers : int'(timers_cfg);
      for (int k = 0; k < 170; k++) begin
        if (lim == 0 || $urandom_range(99) < 8) begin
          send_item(itsb_pkg::op_e'($urandom_range(3)), 4'($urandom), $urandom);
        end else begin
          t = $urandom_range(lim - 1);
          case ($urandom_range(19))
            0: op = itsb_pkg::OpClear;
            1, 2: op = itsb_pkg::OpRead;
            default: op = run_q[t] ? itsb_pkg::OpStop : itsb_pkg::OpStart;
          endcase
          // broken pairs
          if ($urandom_range(19) == 0) op = itsb_pkg::op_e'($urandom_range(1, 2));
          send_item(op, 4'(t), tick(t));
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    timers_cfg = '0;
    for (int t = 0; t < itsb_pkg::NumTimers; t++) begin
      wipe_timer(t);
      now_q[t] = $urandom;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_invalid();
    test_directed_ops();
    test_config_limits();
    test_random_traffic();
    drain();
    $display("Covered %0d items and %0d results over all operations, invalid ids,",
             n_items, n_results);
    $display("register settings 0 to 31, restarts, idle stops, clears and wraparound.");
    if (n_fail == 0 && stats_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[interval_timer_stats_bank_top.f]
+incdir+src
src/itsb_pkg.sv
src/itsb_front.sv
src/itsb_back.sv
src/interval_timer_stats_bank_top.sv
src/itsb_checker.sv
sim/testbench.sv
